// ===== src/ssr_pkg.sv =====
// Shared types and constants for the streaming find-and-replace block.
package ssr_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_BYTES      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_BYTES  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_LENGTH = 2'd3;

    // Register widths fixed by the register map
    localparam int CFG_DATA_W = 64;
    localparam int LEN_W      = 4;

    // Width of the replacement count shown on the result port
    localparam int TOTAL_W = 32;

    // Job queue between classifier and serializer
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    // Per-job control carried alongside the job bytes
    typedef struct packed {
        logic               line_end;  // last result of the job closes a line
        logic               bare;      // single result with no character
        logic [TOTAL_W-1:0] total;     // replacement count after this item
    } t_job_meta;

endpackage

// ===== src/ssr_front.sv =====
// Front end: configuration registers, match window and item classification.
module ssr_front
    import ssr_pkg::*;
#(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8,
    parameter int COUNT_WIDTH     = 32,
    parameter int JOB_LANES       = 8,
    parameter int JOB_CNT_W       = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_valid,
    input  logic [7:0]               i_text_byte,
    input  logic                     i_line_end,
    output logic                     o_job_valid,
    output logic [JOB_LANES*8-1:0]   o_job_bytes,
    output logic [JOB_CNT_W-1:0]     o_job_cnt,
    output t_job_meta                o_job_meta
);

    localparam int WIN_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [CFG_DATA_W-1:0]  r_pat;
    logic [LEN_W-1:0]       r_plen;
    logic [CFG_DATA_W-1:0]  r_repl;
    logic [LEN_W-1:0]       r_rlen;

    logic [7:0]             r_win [MAX_PATTERN];
    logic [7:0]             n_win [MAX_PATTERN];
    logic [WIN_W-1:0]       r_fill;
    logic [WIN_W-1:0]       n_fill;
    logic [COUNT_WIDTH-1:0] r_total;
    logic [COUNT_WIDTH-1:0] n_total;

    logic [7:0]             w_app [MAX_PATTERN];
    logic [LEN_W-1:0]       w_plen;
    logic [LEN_W-1:0]       w_rlen;
    logic [LEN_W-1:0]       w_fill4;
    logic [LEN_W-1:0]       w_n4;
    logic                   w_hit;
    logic                   w_sel_repl;
    logic [63:0]            w_tot64;

    // Lengths beyond the built window or lane count are clipped
    assign w_plen  = (r_plen > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : r_plen;
    assign w_rlen  = (r_rlen > LEN_W'(MAX_REPLACEMENT)) ? LEN_W'(MAX_REPLACEMENT) : r_rlen;
    assign w_fill4 = LEN_W'(r_fill);
    assign w_n4    = w_fill4 + LEN_W'(1);

    // Window with the new byte appended at the fill position
    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            w_app[i] = (WIN_W'(i) == r_fill) ? i_text_byte : r_win[i];
        end
    end

    // Pattern compare over the bytes in use
    always_comb begin
        w_hit = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if ((LEN_W'(i) < w_plen) && (w_app[i] != r_pat[8*i +: 8])) begin
                w_hit = 1'b0;
            end
        end
    end

    // Classify the item: pass through, replace, emit oldest, flush or hold
    always_comb begin
        n_win               = w_app;
        n_fill              = r_fill;
        n_total             = r_total;
        o_job_valid         = 1'b0;
        o_job_cnt           = '0;
        o_job_meta.line_end = i_line_end;
        o_job_meta.bare     = 1'b0;
        w_sel_repl          = 1'b0;
        if (i_valid) begin
            if (w_fill4 >= w_plen) begin
                // empty or shortened pattern: window and byte go out as they are
                o_job_valid = 1'b1;
                o_job_cnt   = JOB_CNT_W'(w_n4);
                n_fill      = '0;
            end else if (w_n4 == w_plen) begin
                if (w_hit) begin
                    if (r_total != '1) begin
                        n_total = r_total + COUNT_WIDTH'(1);
                    end
                    w_sel_repl = 1'b1;
                    n_fill     = '0;
                    if (w_rlen == '0) begin
                        // deleted match closing a line leaves a bare line end
                        o_job_valid     = i_line_end;
                        o_job_cnt       = JOB_CNT_W'(1);
                        o_job_meta.bare = 1'b1;
                    end else begin
                        o_job_valid = 1'b1;
                        o_job_cnt   = JOB_CNT_W'(w_rlen);
                    end
                end else if (i_line_end) begin
                    o_job_valid = 1'b1;
                    o_job_cnt   = JOB_CNT_W'(w_n4);
                    n_fill      = '0;
                end else begin
                    // mismatch: oldest byte leaves, window slides by one
                    o_job_valid         = 1'b1;
                    o_job_cnt           = JOB_CNT_W'(1);
                    o_job_meta.line_end = 1'b0;
                    for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                        n_win[i] = w_app[i+1];
                    end
                end
            end else if (i_line_end) begin
                o_job_valid = 1'b1;
                o_job_cnt   = JOB_CNT_W'(w_n4);
                n_fill      = '0;
            end else begin
                n_fill = WIN_W'(w_n4);
            end
        end
        // Count shown on results, limited to the port width
        w_tot64          = 64'(n_total);
        o_job_meta.total = (w_tot64[63:TOTAL_W] != '0) ? '1 : w_tot64[TOTAL_W-1:0];
    end

    // Job byte lanes: window bytes or replacement bytes
    for (genvar g = 0; g < JOB_LANES; g++) begin : g_lane
        logic [7:0] w_app_lane;
        logic [7:0] w_repl_lane;
        if (g < MAX_PATTERN) begin : g_app
            assign w_app_lane = w_app[g];
        end else begin : g_app_none
            assign w_app_lane = '0;
        end
        if (g < MAX_REPLACEMENT) begin : g_repl
            assign w_repl_lane = r_repl[8*g +: 8];
        end else begin : g_repl_none
            assign w_repl_lane = '0;
        end
        assign o_job_bytes[8*g +: 8] = w_sel_repl ? w_repl_lane : w_app_lane;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_plen <= '0;
            r_repl <= '0;
            r_rlen <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PATTERN_BYTES:      r_pat  <= i_cfg_data;
                CFG_PATTERN_LENGTH:     r_plen <= i_cfg_data[LEN_W-1:0];
                CFG_REPLACEMENT_BYTES:  r_repl <= i_cfg_data;
                CFG_REPLACEMENT_LENGTH: r_rlen <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Window state and replacement counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_total <= '0;
        end else begin
            r_fill  <= n_fill;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

endmodule

// ===== src/ssr_queue.sv =====
// Short job queue that decouples the classifier from the serializer.
module ssr_queue
    import ssr_pkg::*;
#(
    parameter int WIDTH = 110
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0]     r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr;
    logic [QUEUE_PTR_W-1:0] r_rd;
    logic [QUEUE_PTR_W:0]   r_count;
    logic                   w_wr_en;
    logic                   w_rd_en;

    assign o_full  = (r_count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign w_wr_en = i_push && !o_full;
    assign w_rd_en = i_pop && o_valid;

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_wr_en) begin
                r_wr <= r_wr + QUEUE_PTR_W'(1);
            end
            if (w_rd_en) begin
                r_rd <= r_rd + QUEUE_PTR_W'(1);
            end
            case ({w_wr_en, w_rd_en})
                2'b10:   r_count <= r_count + (QUEUE_PTR_W+1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_PTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== src/ssr_back.sv =====
// Back end: walks the head job and presents one result per transfer.
module ssr_back
    import ssr_pkg::*;
#(
    parameter int JOB_LANES = 8,
    parameter int JOB_CNT_W = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_job_valid,
    input  logic [JOB_LANES*8-1:0] i_job_bytes,
    input  logic [JOB_CNT_W-1:0]   i_job_cnt,
    input  t_job_meta              i_job_meta,
    input  logic                   i_pop,
    output logic                   o_job_done,
    output logic                   o_empty,
    output logic [7:0]             o_out_byte,
    output logic                   o_has_byte,
    output logic                   o_out_line_end,
    output logic                   o_last_of_run,
    output logic [TOTAL_W-1:0]     o_total_replacements
);

    localparam int IDX_W = (JOB_LANES > 1) ? $clog2(JOB_LANES) : 1;

    logic [IDX_W-1:0] r_idx;
    logic             w_last;

    assign w_last     = ((JOB_CNT_W'(r_idx) + JOB_CNT_W'(1)) == i_job_cnt);
    assign o_job_done = i_pop && i_job_valid && w_last;

    // Result fields for the current position in the head job
    assign o_empty              = !i_job_valid;
    assign o_has_byte           = !i_job_meta.bare;
    assign o_out_byte           = i_job_meta.bare ? 8'h00 : i_job_bytes[8*r_idx +: 8];
    assign o_out_line_end       = i_job_meta.line_end && w_last;
    assign o_last_of_run        = w_last;
    assign o_total_replacements = i_job_meta.total;

    // Position within the job, back to zero after its last transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_pop && i_job_valid) begin
            if (w_last) begin
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

endmodule

// ===== src/stream_substring_replace.sv =====
// Top level of the streaming find-and-replace block.
//
// Input channel: a text byte with its line-end mark is taken on a clock edge
// with push high and full low. Result channel: while empty is low the oldest
// result is on the o_ ports and is taken on an edge with pop high.
// Configuration: the user must write the registers through i_cfg_we/
// i_cfg_index/i_cfg_data only while the block is idle, which the block
// itself does not enforce. The first result of an item is registered in
// the job queue and shown once its job reaches the head. The front takes
// one byte per cycle while full is low and classifies it against the match
// window; each byte that produces output becomes one job of 1 to 8 results
// in a 4-entry queue, and the back end sends one result per cycle while
// pop is high. Throughput: one item per cycle while each item yields at
// most one result, and input keeps flowing until the job queue fills.
// Stall: a receiver that holds pop low fills the queue; full then rises and
// the front stops taking bytes, with no result lost.
// Reset: synchronous, active low; clears configuration, window fill, the
// replacement counter and the queue. No clearing pass is needed.
module stream_substring_replace
    import ssr_pkg::*;
#(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8,
    parameter int COUNT_WIDTH     = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             i_text_byte,
    input  logic                   i_line_end,
    output logic                   empty,
    input  logic                   pop,
    output logic [7:0]             o_out_byte,
    output logic                   o_has_byte,
    output logic                   o_out_line_end,
    output logic                   o_last_of_run,
    output logic [TOTAL_W-1:0]     o_total_replacements
);

    localparam int JOB_LANES = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
    localparam int JOB_CNT_W = $clog2(JOB_LANES + 1);
    localparam int META_W    = $bits(t_job_meta);
    localparam int Q_W       = JOB_LANES*8 + JOB_CNT_W + META_W;

    logic                   w_in_xfer;
    logic                   w_job_valid;
    logic [JOB_LANES*8-1:0] w_job_bytes;
    logic [JOB_CNT_W-1:0]   w_job_cnt;
    t_job_meta              w_job_meta;
    logic                   w_q_valid;
    logic [Q_W-1:0]         w_q_data;
    logic                   w_q_pop;
    logic [JOB_LANES*8-1:0] w_head_bytes;
    logic [JOB_CNT_W-1:0]   w_head_cnt;
    t_job_meta              w_head_meta;

    assign w_in_xfer = push && !full;

    ssr_front #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT),
        .COUNT_WIDTH     (COUNT_WIDTH),
        .JOB_LANES       (JOB_LANES),
        .JOB_CNT_W       (JOB_CNT_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (w_in_xfer),
        .i_text_byte (i_text_byte),
        .i_line_end  (i_line_end),
        .o_job_valid (w_job_valid),
        .o_job_bytes (w_job_bytes),
        .o_job_cnt   (w_job_cnt),
        .o_job_meta  (w_job_meta)
    );

    ssr_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_valid),
        .i_data  ({w_job_bytes, w_job_cnt, w_job_meta}),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    assign {w_head_bytes, w_head_cnt, w_head_meta} = w_q_data;

    ssr_back #(
        .JOB_LANES (JOB_LANES),
        .JOB_CNT_W (JOB_CNT_W)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_job_valid          (w_q_valid),
        .i_job_bytes          (w_head_bytes),
        .i_job_cnt            (w_head_cnt),
        .i_job_meta           (w_head_meta),
        .i_pop                (pop),
        .o_job_done           (w_q_pop),
        .o_empty              (empty),
        .o_out_byte           (o_out_byte),
        .o_has_byte           (o_has_byte),
        .o_out_line_end       (o_out_line_end),
        .o_last_of_run        (o_last_of_run),
        .o_total_replacements (o_total_replacements)
    );

    // A job is only produced when the queue has room for it
    a_job_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_valid |-> !full)
        else $error("job produced while queue full");

    // A line always closes on the last result of its item
    a_line_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_line_end) |-> o_last_of_run)
        else $error("line end not on last result of item");

    // A result without a character only marks a line end
    a_bare_marks_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_has_byte) |-> (o_out_line_end && o_out_byte == 8'h00))
        else $error("bare result outside a line end");

    // Nothing is waiting right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queue not empty after reset");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the streaming find-and-replace block.
module testbench
    import ssr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_ITEMS    = 32;
    localparam int RANDOM_PHASES  = 6;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       line_end;
    } t_text_item;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               has_byte;
        logic               line_end;
        logic               last_of_run;
        logic [TOTAL_W-1:0] total;
    } t_rewrite_result;

    // Clock, reset and block inputs, all known from time zero
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   push        = 1'b0;
    logic [7:0]             i_text_byte = 8'h00;
    logic                   i_line_end  = 1'b0;
    logic                   pop         = 1'b0;
    logic                   full;
    logic                   empty;
    logic [7:0]             o_out_byte;
    logic                   o_has_byte;
    logic                   o_out_line_end;
    logic                   o_last_of_run;
    logic [TOTAL_W-1:0]     o_total_replacements;

    // Text waiting to be sent and rewritten bytes waiting to come out
    t_text_item      pending_text[$];
    t_rewrite_result expected_rewrites[$];
    t_rewrite_result step_results[$];

    // Shadow of the register file
    logic [63:0] cfg_pattern  = '0;
    logic [3:0]  cfg_pat_len  = '0;
    logic [63:0] cfg_repl     = '0;
    logic [3:0]  cfg_repl_len = '0;

    // Shadow of the match window and replacement count
    logic [7:0]  shadow_window[8];
    int          shadow_fill  = 0;
    logic [31:0] shadow_total = '0;

    logic [7:0]  phase_alpha[2];

    int errors        = 0;
    int sent_count    = 0;
    int checked_count = 0;
    int setting_count = 0;
    int idle_cycles   = 0;

    // Driver state
    int         burst_left = 0;
    int         gap_left   = 0;
    t_text_item taken_item;

    // Receiver state
    int         hold_left = 0;
    bit         hold_done = 1'b0;
    int         mode_left = 0;
    int         rx_mode   = 0;
    logic [7:0] stall_mask = 8'h5B;
    t_rewrite_result want;

    stream_substring_replace dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .push                 (push),
        .full                 (full),
        .i_text_byte          (i_text_byte),
        .i_line_end           (i_line_end),
        .empty                (empty),
        .pop                  (pop),
        .o_out_byte           (o_out_byte),
        .o_has_byte           (o_has_byte),
        .o_out_line_end       (o_out_line_end),
        .o_last_of_run        (o_last_of_run),
        .o_total_replacements (o_total_replacements)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Append one rewritten byte (or bare line end) to this step's output
    function automatic void add_result(input logic has, input logic [7:0] b, input logic le);
        t_rewrite_result r;
        if (step_results.size() >= 8) return;
        r.out_byte    = has ? b : 8'h00;
        r.has_byte    = has;
        r.line_end    = le;
        r.last_of_run = 1'b0;
        r.total       = shadow_total;
        step_results.push_back(r);
    endfunction

    // Emit the window unchanged and clear it
    function automatic void flush_window(input logic le);
        for (int i = 0; i < shadow_fill; i++)
            add_result(1'b1, shadow_window[i], le && (i + 1 == shadow_fill));
        shadow_fill = 0;
        for (int i = 0; i < 8; i++) shadow_window[i] = 8'h00;
    endfunction

    // Advance the shadow window by one text byte and queue what it produces
    function automatic void predict_rewrite(input logic [7:0] b, input logic le);
        int              plen;
        int              rlen;
        logic            hit;
        t_rewrite_result r;
        plen = (cfg_pat_len > 4'd8) ? 8 : int'(cfg_pat_len);
        rlen = (cfg_repl_len > 4'd8) ? 8 : int'(cfg_repl_len);
        step_results.delete();
        if (shadow_fill > 7) shadow_fill = 7;
        if (shadow_fill >= plen) begin
            // empty or shortened pattern: everything passes through
            shadow_window[shadow_fill] = b;
            shadow_fill++;
            flush_window(le);
        end else begin
            shadow_window[shadow_fill] = b;
            shadow_fill++;
            if (shadow_fill == plen) begin
                hit = 1'b1;
                for (int i = 0; i < plen; i++)
                    if (shadow_window[i] != cfg_pattern[8*i +: 8]) hit = 1'b0;
                if (hit) begin
                    if (shadow_total != '1) shadow_total++;
                    for (int i = 0; i < rlen; i++)
                        add_result(1'b1, cfg_repl[8*i +: 8], le && (i + 1 == rlen));
                    shadow_fill = 0;
                    for (int i = 0; i < 8; i++) shadow_window[i] = 8'h00;
                    if (le && rlen == 0) add_result(1'b0, 8'h00, 1'b1);
                end else begin
                    // oldest byte leaves, window slides by one
                    add_result(1'b1, shadow_window[0], le && shadow_fill == 1);
                    for (int i = 1; i < shadow_fill; i++)
                        shadow_window[i-1] = shadow_window[i];
                    shadow_fill--;
                    shadow_window[shadow_fill] = 8'h00;
                    if (le) flush_window(1'b1);
                end
            end else if (le) begin
                flush_window(1'b1);
            end
        end
        if (step_results.size() > 0) begin
            r = step_results.pop_back();
            r.last_of_run = 1'b1;
            step_results.push_back(r);
        end
        foreach (step_results[i]) expected_rewrites.push_back(step_results[i]);
    endfunction

    function automatic void add_text(input logic [7:0] b, input logic le);
        t_text_item t;
        t.text_byte = b;
        t.line_end  = le;
        pending_text.push_back(t);
    endfunction

    // Single-cycle register write, shadow updated at the same edge
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PATTERN_BYTES:      cfg_pattern  = value;
            CFG_PATTERN_LENGTH:     cfg_pat_len  = value[3:0];
            CFG_REPLACEMENT_BYTES:  cfg_repl     = value;
            CFG_REPLACEMENT_LENGTH: cfg_repl_len = value[3:0];
            default: ;
        endcase
    endtask

    // Sender waits for all text to go out and all results to come back
    task automatic drain_and_settle();
        do @(posedge i_clk);
        while (pending_text.size() != 0 || push || expected_rewrites.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // New pattern and replacement for one random phase
    task automatic random_settings(input int phase);
        logic [63:0] pat;
        logic [63:0] rep;
        logic [63:0] plen_word;
        logic [63:0] rlen_word;
        phase_alpha[0] = 8'($urandom);
        phase_alpha[1] = 8'($urandom);
        pat = {$urandom, $urandom};
        rep = {$urandom, $urandom};
        if (phase != RANDOM_PHASES - 1)
            for (int i = 0; i < 8; i++) pat[8*i +: 8] = phase_alpha[$urandom_range(0, 1)];
        plen_word = {$urandom, $urandom};
        rlen_word = {$urandom, $urandom};
        case (phase)
            0:       plen_word[3:0] = 4'd1;
            1:       plen_word[3:0] = 4'd3;
            2:       plen_word[3:0] = 4'd8;
            3:       plen_word[3:0] = 4'd0;
            4:       plen_word[3:0] = 4'd2;
            default: plen_word[3:0] = 4'($urandom_range(0, 15));
        endcase
        case (phase)
            2:       rlen_word[3:0] = 4'd8;
            3:       rlen_word[3:0] = 4'd0;
            default: rlen_word[3:0] = 4'($urandom_range(0, 15));
        endcase
        write_reg(CFG_PATTERN_BYTES, pat);
        write_reg(CFG_PATTERN_LENGTH, plen_word);
        write_reg(CFG_REPLACEMENT_BYTES, rep);
        write_reg(CFG_REPLACEMENT_LENGTH, rlen_word);
        setting_count++;
    endtask

    // Text built mostly from whole and partial patterns, some noise
    task automatic build_random_text(input int count);
        int n;
        int sel;
        int plen;
        int span;
        n = 0;
        plen = (cfg_pat_len > 4'd8) ? 8 : int'(cfg_pat_len);
        while (n < count) begin
            sel = $urandom_range(0, 9);
            if (sel < 6 && plen > 0) begin
                span = (sel < 4 || plen == 1) ? plen : $urandom_range(1, plen - 1);
                for (int i = 0; i < span; i++)
                    add_text(cfg_pattern[8*i +: 8],
                             (i == span - 1) && ($urandom_range(0, 3) == 0));
                n += span;
            end else begin
                add_text((sel < 9) ? phase_alpha[$urandom_range(0, 1)] : 8'($urandom),
                         $urandom_range(0, 7) == 0);
                n++;
            end
        end
    endtask

    // Stimulus sequence: directed cases, then random phases
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // pass-through with reset settings
        add_text(8'h00, 1'b0);
        add_text(8'hFF, 1'b1);
        add_text(8'h5A, 1'b0);
        drain_and_settle();

        // "ab" -> "XYZ"
        write_reg(CFG_PATTERN_BYTES, 64'h0000_0000_0000_6261);
        write_reg(CFG_PATTERN_LENGTH, 64'd2);
        write_reg(CFG_REPLACEMENT_BYTES, 64'h0000_0000_005A_5958);
        write_reg(CFG_REPLACEMENT_LENGTH, 64'd3);
        setting_count++;
        add_text("a", 1'b0);
        add_text("b", 1'b0);
        add_text("a", 1'b0);
        add_text("a", 1'b0);
        add_text("b", 1'b1);
        add_text("c", 1'b0);
        add_text("a", 1'b1);
        drain_and_settle();

        // deleted match at end of line leaves a bare line end
        write_reg(CFG_REPLACEMENT_LENGTH, 64'd0);
        setting_count++;
        add_text("a", 1'b0);
        add_text("b", 1'b1);
        drain_and_settle();

        // oversized lengths clamp to eight, full-width match and replacement
        write_reg(CFG_PATTERN_BYTES, 64'hFF00_807F_01FE_AA55);
        write_reg(CFG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_REPLACEMENT_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_REPLACEMENT_LENGTH, 64'h0000_0000_0000_000F);
        setting_count++;
        for (int i = 0; i < 8; i++) add_text(cfg_pattern[8*i +: 8], i == 7);
        for (int i = 0; i < 3; i++) add_text(cfg_pattern[8*i +: 8], 1'b0);
        drain_and_settle();

        // pattern shortened while the window holds three bytes
        write_reg(CFG_PATTERN_LENGTH, 64'd2);
        setting_count++;
        add_text(8'h3C, 1'b0);
        drain_and_settle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_settings(p);
            build_random_text(PHASE_ITEMS);
            drain_and_settle();
        end

        if (expected_rewrites.size() != 0) begin
            $error("%0d expected results never arrived", expected_rewrites.size());
            errors++;
        end
        $display("Sent %0d text bytes under %0d register settings, checked %0d results.",
                 sent_count, setting_count, checked_count);
        $display("Replacements counted: %0d; receiver long hold-off done: %0d.",
                 shadow_total, hold_done);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Driver: bursts of transfers separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                taken_item = pending_text.pop_front();
                predict_rewrite(taken_item.text_byte, taken_item.line_end);
                sent_count++;
            end
            // an item held by full stays on the bus untouched
            if (!push || !full) begin
                if (burst_left == 0) begin
                    gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
                    burst_left = $urandom_range(1, 20);
                end
                if (gap_left > 0) begin
                    gap_left--;
                    push <= 1'b0;
                end else if (pending_text.size() != 0) begin
                    push        <= 1'b1;
                    i_text_byte <= pending_text[0].text_byte;
                    i_line_end  <= pending_text[0].line_end;
                    burst_left--;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer, then choose the next pop
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                checked_count++;
                if (expected_rewrites.size() == 0) begin
                    $error("unexpected result: out_byte %h has_byte %b", o_out_byte, o_has_byte);
                    errors++;
                end else begin
                    want = expected_rewrites.pop_front();
                    if (o_out_byte !== want.out_byte) begin
                        $error("out_byte: expected %h, actual %h", want.out_byte, o_out_byte);
                        errors++;
                    end
                    if (o_has_byte !== want.has_byte) begin
                        $error("has_byte: expected %b, actual %b", want.has_byte, o_has_byte);
                        errors++;
                    end
                    if (o_out_line_end !== want.line_end) begin
                        $error("out_line_end: expected %b, actual %b",
                               want.line_end, o_out_line_end);
                        errors++;
                    end
                    if (o_last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %b, actual %b",
                               want.last_of_run, o_last_of_run);
                        errors++;
                    end
                    if (o_total_replacements !== want.total) begin
                        $error("total_replacements: expected %0d, actual %0d",
                               want.total, o_total_replacements);
                        errors++;
                    end
                end
            end
            // one long hold-off while text keeps coming, so full must rise
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (!hold_done && sent_count >= 30) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                pop <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode    = $urandom_range(0, 2);
                    mode_left  = $urandom_range(16, 64);
                    stall_mask = 8'($urandom_range(1, 255));
                end
                mode_left--;
                case (rx_mode)
                    0: pop <= 1'b1;
                    1: pop <= 1'($urandom_range(0, 1));
                    default: begin
                        pop        <= stall_mask[0];
                        stall_mask  = {stall_mask[0], stall_mask[7:1]};
                    end
                endcase
            end
        end
    end

    // Watchdog: too long without any transfer or register write
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || i_cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
